[rtl/ssh_pkg.sv]
package ssh_pkg;

	// Quotient bits produced by each divider lane; covers the widest unclamped factor.
	localparam int QW         = 22;
	localparam int DEN_W      = 15;
	localparam int MAG_W      = 17;
	localparam int Q14_SH     = 14;
	localparam int NUM_W      = MAG_W + Q14_SH;
	localparam int BPS        = 2;
	localparam int DIV_STAGES = QW / BPS;
	localparam int FAC_W      = QW + 1;
	localparam int SUM_W      = 27;
	localparam int PROD_W     = 43;
	localparam int V_W        = 18;
	localparam int IDX_W      = 16;
	localparam int LANES      = 4;

	localparam logic [IDX_W-1:0] ONE_Q14   = 16'd16384;
	localparam logic [V_W-1:0]   V_MAX     = 18'd163844;
	localparam logic [15:0]      RECIP5    = 16'd52429;
	localparam int               RECIP_SH  = 18;
	localparam int               SCALE_SH  = 15;

	typedef enum logic [2:0] {
		REG_PH_LO    = 3'd0,
		REG_PH_HI    = 3'd1,
		REG_MOIST_LO = 3'd2,
		REG_MOIST_HI = 3'd3,
		REG_TEMP_LO  = 3'd4,
		REG_TEMP_HI  = 3'd5,
		REG_BASE     = 3'd6
	} ssh_reg_t;

	typedef struct packed {
		logic              inb;
		logic              zero;
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic [DEN_W-1:0]  den;
	} ssh_lane_t;

	typedef struct packed {
		logic           inb;
		logic           zero;
		logic           neg;
		logic [QW-1:0]  quo;
	} ssh_quo_t;

	typedef struct packed {
		logic        rec_valid;
		logic [2:0]  cnt;
	} ssh_meta_t;

endpackage

[rtl/soil_sensor_health_score.sv]
// Channel   Handshake                Payload
// record    start (busy always low)  ph_centi, moisture_pct, temp_centi, conductivity
// result    done, one cycle          resilience_index, record_valid, band_count
// config    cfg_we                   cfg_index, cfg_data
//
// One record is taken every cycle; its result appears on done after
// one setup stage, eleven stages of the per-factor dividers (two quotient bits
// each) and four scoring stages. Reset clears the band registers to their
// defaults and empties the pipeline. The receiver cannot hold results off.
module soil_sensor_health_score (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [15:0]        ph_centi,
	input  logic signed [7:0]         moisture_pct,
	input  logic signed [15:0]        temp_centi,
	input  logic signed [15:0]        conductivity,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [14:0]               cfg_data,
	output logic                      done,
	output logic [15:0]               resilience_index,
	output logic                      record_valid,
	output logic [2:0]                band_count
);
	import ssh_pkg::*;

	// Band test and rule selection for one field; the divisor falls back to one.
	function automatic ssh_lane_t lane_setup(
		input logic signed [17:0] x,
		input logic signed [17:0] lo,
		input logic signed [17:0] hi,
		input logic signed [17:0] lo_limit,
		input logic               clamp_lo,
		input logic signed [17:0] hi_limit
	);
		ssh_lane_t r;
		logic signed [17:0] num;
		logic signed [17:0] den;
		r.inb = (x >= lo) && (x <= hi);
		if (x < lo) begin
			r.zero = clamp_lo && (x <= lo_limit);
			num    = x - lo_limit;
			den    = lo - lo_limit;
		end else begin
			r.zero = x >= hi_limit;
			num    = hi_limit - x;
			den    = hi_limit - hi;
		end
		r.neg = num[17];
		r.mag = MAG_W'(r.neg ? -num : num);
		r.den = (den <= 18'sd0) ? DEN_W'(1) : DEN_W'(den);
		return r;
	endfunction

	logic [10:0] ph_lo_q, ph_hi_q;
	logic [6:0]  moist_lo_q, moist_hi_q;
	logic [14:0] temp_lo_q, temp_hi_q;
	logic [14:0] base_q;

	ssh_lane_t   lane   [LANES];
	ssh_lane_t   lane_s1 [LANES];
	ssh_meta_t   meta;
	ssh_meta_t   meta_s1;
	logic        vld_s1;
	ssh_meta_t   meta_d [DIV_STAGES];
	ssh_quo_t    quo    [LANES];
	logic [LANES-1:0] div_vld;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_lo_q    <= 11'd600;
			ph_hi_q    <= 11'd750;
			moist_lo_q <= 7'd30;
			moist_hi_q <= 7'd60;
			temp_lo_q  <= 15'd1000;
			temp_hi_q  <= 15'd3000;
			base_q     <= 15'd16384;
		end else if (cfg_we) begin
			case (ssh_reg_t'(cfg_index))
				REG_PH_LO:    ph_lo_q    <= cfg_data[10:0];
				REG_PH_HI:    ph_hi_q    <= cfg_data[10:0];
				REG_MOIST_LO: moist_lo_q <= cfg_data[6:0];
				REG_MOIST_HI: moist_hi_q <= cfg_data[6:0];
				REG_TEMP_LO:  temp_lo_q  <= cfg_data;
				REG_TEMP_HI:  temp_hi_q  <= cfg_data;
				REG_BASE:     base_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		lane[0] = lane_setup(18'(ph_centi), 18'(ph_lo_q), 18'(ph_hi_q),
			18'sd0, 1'b1, 18'sd1400);
		lane[1] = lane_setup(18'(moisture_pct), 18'(moist_lo_q), 18'(moist_hi_q),
			18'sd0, 1'b0, 18'sd100);
		lane[2] = lane_setup(18'(temp_centi), 18'(signed'(temp_lo_q)),
			18'(signed'(temp_hi_q)), -18'sd4000, 1'b1, 18'sd8500);
		lane[3] = lane_setup(18'(conductivity), 18'sd200, 18'sd800,
			18'sd0, 1'b0, 18'sd2000);
		meta.rec_valid = (ph_centi >= 0) && (ph_centi <= 1400)
			&& (moisture_pct >= 0) && (moisture_pct <= 100)
			&& (temp_centi >= -4000) && (temp_centi <= 8500)
			&& (conductivity >= 0) && (conductivity <= 10000);
		meta.cnt = {2'b0, lane[0].inb} + {2'b0, lane[1].inb}
			+ {2'b0, lane[2].inb} + {2'b0, lane[3].inb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane;
		meta_s1 <= meta;
	end

	// Record flag and count ride alongside the dividers.
	always_ff @(posedge clk) begin
		meta_d[0] <= meta_s1;
		for (int i = 1; i < DIV_STAGES; i++) begin
			meta_d[i] <= meta_d[i-1];
		end
	end

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			ssh_div u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (vld_s1),
				.lane      (lane_s1[g]),
				.out_valid (div_vld[g]),
				.result    (quo[g])
			);
		end
	endgenerate

	ssh_score u_score (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (&div_vld),
		.quo              (quo),
		.meta             (meta_d[DIV_STAGES-1]),
		.base_scale       (base_q),
		.done             (done),
		.resilience_index (resilience_index),
		.record_valid     (record_valid),
		.band_count       (band_count)
	);

endmodule

[rtl/ssh_div.sv]
module ssh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ssh_pkg::ssh_lane_t lane,
	output logic              out_valid,
	output ssh_pkg::ssh_quo_t  result
);
	import ssh_pkg::*;

	typedef struct packed {
		logic              inb;
		logic              zero;
		logic              neg;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [QW-1:0]     bits;
		logic [QW-1:0]     quo;
	} ssh_dstage_t;

	// Restoring long division, BPS quotient bits per stage.
	function automatic ssh_dstage_t div_steps(input ssh_dstage_t a);
		ssh_dstage_t r;
		logic [DEN_W:0] t;
		r = a;
		for (int i = 0; i < BPS; i++) begin
			t = {r.rem, r.bits[QW-1]};
			r.bits = {r.bits[QW-2:0], 1'b0};
			if (t >= {1'b0, r.den}) begin
				t = t - {1'b0, r.den};
				r.quo = {r.quo[QW-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[QW-2:0], 1'b0};
			end
			r.rem = t[DEN_W-1:0];
		end
		return r;
	endfunction

	logic [NUM_W-1:0] numer;
	ssh_dstage_t      head;
	ssh_dstage_t      div_s [DIV_STAGES];
	logic             vld_s [DIV_STAGES];

	// The numerator is mag * 16384; its bits above the quotient width are
	// always below the divisor in the cases whose result is used.
	always_comb begin
		numer     = {lane.mag, {Q14_SH{1'b0}}};
		head.inb  = lane.inb;
		head.zero = lane.zero;
		head.neg  = lane.neg;
		head.den  = lane.den;
		head.rem  = DEN_W'(numer >> QW);
		head.bits = numer[QW-1:0];
		head.quo  = '0;
	end

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_stage
			if (g == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[g] <= 1'b0;
					end else begin
						vld_s[g] <= in_valid;
					end
				end
				always_ff @(posedge clk) begin
					div_s[g] <= div_steps(head);
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[g] <= 1'b0;
					end else begin
						vld_s[g] <= vld_s[g-1];
					end
				end
				always_ff @(posedge clk) begin
					div_s[g] <= div_steps(div_s[g-1]);
				end
			end
		end
	endgenerate

	assign out_valid   = vld_s[DIV_STAGES-1];
	assign result.inb  = div_s[DIV_STAGES-1].inb;
	assign result.zero = div_s[DIV_STAGES-1].zero;
	assign result.neg  = div_s[DIV_STAGES-1].neg;
	assign result.quo  = div_s[DIV_STAGES-1].quo;

endmodule

[rtl/ssh_score.sv]
module ssh_score (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  ssh_pkg::ssh_quo_t         quo [ssh_pkg::LANES],
	input  ssh_pkg::ssh_meta_t        meta,
	input  logic [14:0]               base_scale,
	output logic                      done,
	output logic [ssh_pkg::IDX_W-1:0] resilience_index,
	output logic                      record_valid,
	output logic [2:0]                band_count
);
	import ssh_pkg::*;

	function automatic logic signed [SUM_W-1:0] fac(input ssh_quo_t q);
		logic signed [FAC_W-1:0] f;
		if (q.inb) begin
			f = FAC_W'(ONE_Q14);
		end else if (q.zero) begin
			f = '0;
		end else if (q.neg) begin
			f = -signed'({1'b0, q.quo});
		end else begin
			f = signed'({1'b0, q.quo});
		end
		return SUM_W'(f);
	endfunction

	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic [V_W-1:0]           v_s3;
	logic [PROD_W-SCALE_SH-1:0] sh;
	logic [V_W-1:0]           v;
	logic [V_W+15:0]          rmul;
	logic [IDX_W-1:0]         idx_s4;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	ssh_meta_t                meta_s1, meta_s2, meta_s3, meta_s4;

	always_comb begin
		sum = SUM_W'(6) * fac(quo[0]) + SUM_W'(7) * fac(quo[1])
			+ SUM_W'(4) * fac(quo[2]) + SUM_W'(3) * fac(quo[3]);
	end

	// A negative product truncates to a value at or below zero, which clamps to zero.
	// Capping before the divide by five keeps the reciprocal exact and the result at most 2.0.
	always_comb begin
		sh = prod_s2[PROD_W-1:SCALE_SH];
		if (prod_s2[PROD_W-1]) begin
			v = '0;
		end else if (sh > (PROD_W-SCALE_SH)'(V_MAX)) begin
			v = V_MAX;
		end else begin
			v = sh[V_W-1:0];
		end
		rmul = v_s3 * RECIP5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1  <= sum;
		meta_s1 <= meta;
		prod_s2 <= PROD_W'(signed'({1'b0, base_scale})) * PROD_W'(sum_s1);
		meta_s2 <= meta_s1;
		v_s3    <= v;
		meta_s3 <= meta_s2;
		idx_s4  <= rmul[RECIP_SH+IDX_W-1:RECIP_SH];
		meta_s4 <= meta_s3;
	end

	assign done             = vld_s4;
	assign resilience_index = idx_s4;
	assign record_valid     = meta_s4.rec_valid;
	assign band_count       = meta_s4.cnt;

endmodule
